>>> design/sha1_pkg.sv
// ---------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 hash engine.
// ---------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 80;

  // Request operations
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] H_INIT [NumChain] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

  localparam logic [6:0] LAST_ROUND = 7'(NumRounds - 1);
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [2:0] LAST_WORD  = 3'(NumChain - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_LEN,
    ST_OUT
  } state_e;

  // Commands to the block buffer / message schedule
  typedef struct packed {
    logic        wr_byte;
    logic        pad;
    logic        put_len;
    logic        len_blk;
    logic        shift;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } sched_ctrl_t;

  // Commands to the round unit
  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic add;
  } round_ctrl_t;

  typedef struct packed {
    logic round_last;
  } round_stat_t;

endpackage

`default_nettype wire

>>> design/sha1_if.sv
// ---------------------------------------------------------------------------
// sha1_if
// Valid/ready channels of the SHA-1 engine: byte requests in, digest out.
// ---------------------------------------------------------------------------
`default_nettype none

interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha1_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

`default_nettype wire

>>> design/sha1_hash_engine.sv
// Flow: a data byte request is taken while the engine is idle; the 64th byte
// of a block then holds ready low for the load, the 80 rounds and the chain add.
// Finish: one final block, or two when padding spills into a second (the ST_LEN
// state loads the length block), then the five digest words.
// No byte is taken while the single round unit compresses a block.
// Reset: asynchronous, active low; chain returns to the SHA-1 initial values.
// ---------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 over a byte stream with a sequencer around one shared round unit.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sha1_req_if.sink    req_i,
  sha1_dig_if.source  dig_o
);

  sha1_pkg::state_e      state_q, state_d;
  sha1_pkg::sched_ctrl_t sc;
  sha1_pkg::round_ctrl_t rc;
  sha1_pkg::round_stat_t rs;

  logic [60:0] total_q, total_d;
  logic        fin_q, fin_d;
  logic        two_q, two_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] w_cur;
  logic [31:0] chain [sha1_pkg::NumChain];
  logic [5:0]  pos;

  assign pos = total_q[5:0];

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sc),
    .w_o    (w_cur)
  );

  sha1_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rc),
    .w_i     (w_cur),
    .stat_o  (rs),
    .chain_o (chain)
  );

  // Sequencer: next state and unit commands
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    fin_d   = fin_q;
    two_d   = two_q;
    idx_d   = idx_q;

    sc         = '0;
    sc.pos     = pos;
    sc.data    = req_i.data_byte;
    sc.bit_len = {total_q, 3'b000};
    rc         = '0;

    req_i.ready = (state_q == sha1_pkg::ST_IDLE);
    dig_o.valid = (state_q == sha1_pkg::ST_OUT);

    case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.op == sha1_pkg::OP_APPEND) begin
            sc.wr_byte = 1'b1;
            total_d    = total_q + 61'd1;
            if (pos == sha1_pkg::LAST_POS) begin
              state_d = sha1_pkg::ST_LOAD;
            end
          end else begin
            sc.pad     = 1'b1;
            sc.put_len = (pos < sha1_pkg::LEN_POS);
            fin_d      = 1'b1;
            two_d      = (pos >= sha1_pkg::LEN_POS);
            state_d    = sha1_pkg::ST_LOAD;
          end
        end
      end
      sha1_pkg::ST_LOAD: begin
        rc.load = 1'b1;
        state_d = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        rc.step  = 1'b1;
        sc.shift = 1'b1;
        if (rs.round_last) begin
          state_d = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        rc.add = 1'b1;
        if (fin_q && two_q) begin
          state_d = sha1_pkg::ST_LEN;
        end else if (fin_q) begin
          state_d = sha1_pkg::ST_OUT;
        end else begin
          state_d = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_LEN: begin
        sc.len_blk = 1'b1;
        two_d      = 1'b0;
        state_d    = sha1_pkg::ST_LOAD;
      end
      sha1_pkg::ST_OUT: begin
        if (dig_o.ready) begin
          if (idx_q == sha1_pkg::LAST_WORD) begin
            rc.init = 1'b1;
            fin_d   = 1'b0;
            total_d = '0;
            idx_d   = 3'd0;
            state_d = sha1_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // Digest word select
  always_comb begin
    case (idx_q)
      3'd0:    dig_o.digest_word = chain[0];
      3'd1:    dig_o.digest_word = chain[1];
      3'd2:    dig_o.digest_word = chain[2];
      3'd3:    dig_o.digest_word = chain[3];
      3'd4:    dig_o.digest_word = chain[4];
      default: dig_o.digest_word = 32'h0;
    endcase
  end

  assign dig_o.word_index = idx_q;
  assign dig_o.last       = (idx_q == sha1_pkg::LAST_WORD);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::ST_IDLE;
      total_q <= '0;
      fin_q   <= 1'b0;
      two_q   <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      fin_q   <= fin_d;
      two_q   <= two_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sha1_sched.sv
// ---------------------------------------------------------------------------
// sha1_sched
// Block buffer that packs bytes, applies padding and then runs as the
// 16-word message schedule shift line during compression.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_sched (
  input  wire logic                  clk_i,
  input  wire sha1_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]                w_o
);

  logic [31:0] buf_q [sha1_pkg::NumWords];
  logic [31:0] buf_d [sha1_pkg::NumWords];
  logic [3:0]  wsel;
  logic [1:0]  boff;
  logic [4:0]  byte_sh;
  logic [4:0]  pad_sh;
  logic [31:0] byte_val;
  logic [31:0] keep_mask;
  logic [31:0] pad_val;

  assign w_o   = buf_q[0];

  assign wsel      = ctrl_i.pos[5:2];
  assign boff      = ctrl_i.pos[1:0];
  assign byte_sh   = {~boff, 3'b000};
  assign pad_sh    = {boff, 3'b000};
  assign byte_val  = {24'h0, ctrl_i.data} << byte_sh;
  assign keep_mask = ~(32'hFFFF_FFFF >> pad_sh);
  assign pad_val   = 32'h8000_0000 >> pad_sh;

  always_comb begin
    logic [31:0] x;
    x = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];
    for (int i = 0; i < sha1_pkg::NumWords; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (ctrl_i.shift) begin
      // Advance the schedule by one word
      for (int i = 0; i < sha1_pkg::NumWords - 1; i++) begin
        buf_d[i] = buf_q[i + 1];
      end
      buf_d[sha1_pkg::NumWords - 1] = {x[30:0], x[31]};
    end else if (ctrl_i.wr_byte) begin
      // Pack one byte big-endian; the first byte of a word clears it
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        if (4'(i) == wsel) begin
          buf_d[i] = (boff == 2'd0) ? byte_val : (buf_q[i] | byte_val);
        end
      end
    end else if (ctrl_i.pad) begin
      // Insert the 1 bit, zero the rest, optionally drop in the length
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        if (4'(i) == wsel) begin
          buf_d[i] = (buf_q[i] & keep_mask) | pad_val;
        end else if (4'(i) > wsel) begin
          buf_d[i] = 32'h0;
        end
      end
      if (ctrl_i.put_len) begin
        buf_d[14] = ctrl_i.bit_len[63:32];
        buf_d[15] = ctrl_i.bit_len[31:0];
      end
    end else if (ctrl_i.len_blk) begin
      // Extra block holding only zeros and the length
      for (int i = 0; i < sha1_pkg::NumWords - 2; i++) begin
        buf_d[i] = 32'h0;
      end
      buf_d[14] = ctrl_i.bit_len[63:32];
      buf_d[15] = ctrl_i.bit_len[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

>>> design/sha1_round.sv
// ---------------------------------------------------------------------------
// sha1_round
// Shared round unit: working words a..e, round counter and chaining words.
// One round per cycle; the final add updates all five chaining words at once.
// ---------------------------------------------------------------------------
`default_nettype none

module sha1_round (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sha1_pkg::round_ctrl_t ctrl_i,
  input  wire logic [31:0]           w_i,
  output sha1_pkg::round_stat_t      stat_o,
  output logic [31:0]                chain_o [sha1_pkg::NumChain]
);

  logic [31:0] chain_q [sha1_pkg::NumChain];
  logic [31:0] work_q  [sha1_pkg::NumChain];
  logic [6:0]  round_q;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] a, b, c, d, e;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  assign chain_o           = chain_q;
  assign stat_o.round_last = (round_q == sha1_pkg::LAST_ROUND);

  // Select round function and constant by round group
  always_comb begin
    if (round_q < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = sha1_pkg::K_ROUND0;
    end else if (round_q < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = sha1_pkg::K_ROUND1;
    end else if (round_q < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = sha1_pkg::K_ROUND2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = sha1_pkg::K_ROUND3;
    end
  end

  assign t_val = {a[26:0], a[31:27]} + f_val + e + w_i + k_val;

  // Working words
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      work_q <= chain_q;
    end else if (ctrl_i.step) begin
      work_q[0] <= t_val;
      work_q[1] <= a;
      work_q[2] <= {b[1:0], b[31:2]};
      work_q[3] <= c;
      work_q[4] <= d;
    end
  end

  // Round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= 7'd0;
    end else if (ctrl_i.load) begin
      round_q <= 7'd0;
    end else if (ctrl_i.step) begin
      round_q <= round_q + 7'd1;
    end
  end

  // Chaining words: add after a block, restore after a digest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha1_pkg::H_INIT;
    end else if (ctrl_i.init) begin
      chain_q <= sha1_pkg::H_INIT;
    end else if (ctrl_i.add) begin
      for (int i = 0; i < sha1_pkg::NumChain; i++) begin
        chain_q[i] <= chain_q[i] + work_q[i];
      end
    end
  end

endmodule

`default_nettype wire
